@@ rtl/core/pool_pump_heater_mode_controller_defines.svh @@
// Assertion macros shared by the checker of the pool pump and heater mode controller.
// Standalone header; no other includes.
`ifndef POOL_PUMP_HEATER_MODE_CONTROLLER_DEFINES_SVH
`define POOL_PUMP_HEATER_MODE_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PPHMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pphmc check failed");

// next-cycle implication, disabled during reset
`define PPHMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pphmc check failed");

`endif

@@ rtl/core/pphmc_pkg.sv @@
// Shared types and constants of the pool pump and heater mode controller.
// No dependencies.
package pphmc_pkg;

	localparam int TIME_W = 32;
	localparam int TEMP_W = 12;
	localparam int HYST_W = 8;
	localparam int COOL_W = 16;
	localparam int REQ_W  = 3;
	localparam int MODE_W = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SET_OFF  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SET_FILT = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SET_HEAT = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SET_MAINT = 3'd4;

	localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FILT  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HEAT  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_MAINT = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_CRIT_TEMP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HYST      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 2'd2;

	localparam logic signed [TEMP_W-1:0] CRIT_TEMP_RST = 12'sd640;
	localparam logic [HYST_W-1:0]        HYST_RST      = 8'd16;
	localparam logic [COOL_W-1:0]        COOLDOWN_RST  = 16'd300;
	// 35 degrees in 1/16 degree
	localparam logic signed [TEMP_W-1:0] SETPOINT_RST  = 12'sd560;

endpackage

@@ rtl/core/pool_pump_heater_mode_controller.sv @@
// Top level of the pool pump and heater mode controller: input stage, mode logic, result register.
// Depends on pphmc_pkg.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------------------------
//  in      | in_valid / in_ready   | req_type, now_seconds, water_temperature, target_temperature,
//          |                       | run_seconds
//  out     | out_valid / out_ready | pump_on, heater_on, mode_now, rejected
//  cfg     | cfg_wr_en             | cfg_index, cfg_wdata (write only, no wait)
//
// One transaction per cycle sustained while out_ready is high.
// The input register feeds one pass of compare/subtract logic that updates the mode state and
// loads the result register in the same cycle.
// A stalled result holds the input stage; in_ready follows out_ready combinationally.
// arst_n clears the handshake state, mode state and configuration registers to reset values.
module pool_pump_heater_mode_controller
	import pphmc_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [REQ_W-1:0]             req_type,
	input  logic [TIME_W-1:0]            now_seconds,
	input  logic signed [TEMP_W-1:0]     water_temperature,
	input  logic signed [TEMP_W-1:0]     target_temperature,
	input  logic [TIME_W-1:0]            run_seconds,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         pump_on,
	output logic                         heater_on,
	output logic [MODE_W-1:0]            mode_now,
	output logic                         rejected,
	input  logic                         cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

	// configuration
	logic signed [TEMP_W-1:0] crit_temp_q;
	logic [HYST_W-1:0]        hyst_q;
	logic [COOL_W-1:0]        cooldown_q;

	// input stage
	logic                     valid_s1;
	logic [REQ_W-1:0]         req_s1;
	logic [TIME_W-1:0]        now_s1;
	logic signed [TEMP_W-1:0] water_s1;
	logic signed [TEMP_W-1:0] target_s1;
	logic [TIME_W-1:0]        len_s1;

	// mode state
	logic [MODE_W-1:0]        mode_q;
	logic [TIME_W-1:0]        start_q;
	logic [TIME_W-1:0]        run_len_q;
	logic [TIME_W-1:0]        heater_off_q;
	logic signed [TEMP_W-1:0] setpoint_q;
	logic                     pump_q;
	logic                     heater_q;

	// result stage
	logic                     valid_s2;
	logic                     rej_s2;

	// next state
	logic [MODE_W-1:0]        mode_d;
	logic [TIME_W-1:0]        start_d;
	logic [TIME_W-1:0]        run_len_d;
	logic [TIME_W-1:0]        heater_off_d;
	logic signed [TEMP_W-1:0] setpoint_d;
	logic                     pump_d;
	logic                     heater_d;
	logic                     rej_d;

	logic                     advance;
	logic [TIME_W-1:0]        run_elapsed;
	logic [TIME_W-1:0]        cool_elapsed;
	logic                     run_done;
	logic                     cool_done;
	logic signed [TEMP_W:0]   water_hyst;
	logic                     below_sp;
	logic                     below_tg;
	logic                     over_crit;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign run_elapsed  = now_s1 - start_q;
	assign cool_elapsed = now_s1 - heater_off_q;
	assign run_done     = run_elapsed >= run_len_q;
	assign cool_done    = cool_elapsed >= {{(TIME_W-COOL_W){1'b0}}, cooldown_q};
	assign water_hyst   = {water_s1[TEMP_W-1], water_s1} + $signed({1'b0, {(TEMP_W-HYST_W){1'b0}}, hyst_q});
	assign below_sp     = water_hyst < $signed({setpoint_q[TEMP_W-1], setpoint_q});
	assign below_tg     = water_hyst < $signed({target_s1[TEMP_W-1], target_s1});
	assign over_crit    = target_s1 > crit_temp_q;

	always_comb begin
		mode_d       = mode_q;
		start_d      = start_q;
		run_len_d    = run_len_q;
		heater_off_d = heater_off_q;
		setpoint_d   = setpoint_q;
		pump_d       = pump_q;
		heater_d     = heater_q;
		rej_d        = 1'b0;
		case (req_s1)
			REQ_TICK: begin
				case (mode_q)
					MODE_FILT: begin
						if (run_done) begin
							mode_d   = MODE_OFF;
							pump_d   = 1'b0;
							heater_d = 1'b0;
						end
					end
					MODE_HEAT: begin
						if (water_s1 >= setpoint_q) begin
							mode_d    = MODE_FILT;
							start_d   = now_s1;
							run_len_d = {{(TIME_W-COOL_W){1'b0}}, cooldown_q};
							pump_d    = 1'b1;
							heater_d  = 1'b0;
						end
					end
					MODE_MAINT: begin
						if (run_done) begin
							heater_d = 1'b0;
							if (heater_q) begin
								mode_d    = MODE_FILT;
								start_d   = now_s1;
								run_len_d = {{(TIME_W-COOL_W){1'b0}}, cooldown_q};
								pump_d    = 1'b1;
							end else begin
								mode_d = MODE_OFF;
								pump_d = 1'b0;
							end
						end else if (below_sp) begin
							pump_d       = 1'b1;
							heater_d     = 1'b1;
							heater_off_d = '0;
						end else if (water_s1 > setpoint_q && heater_off_q == '0) begin
							// heater just stopped: start timed cool-down
							pump_d       = 1'b1;
							heater_d     = 1'b0;
							heater_off_d = now_s1;
						end else if (heater_off_q != '0 && cool_done) begin
							pump_d       = 1'b0;
							heater_d     = 1'b0;
							heater_off_d = '0;
						end
					end
					default: begin
					end
				endcase
			end
			REQ_SET_OFF: begin
				mode_d   = MODE_OFF;
				pump_d   = 1'b0;
				heater_d = 1'b0;
			end
			REQ_SET_FILT: begin
				mode_d    = MODE_FILT;
				start_d   = now_s1;
				run_len_d = len_s1;
				pump_d    = 1'b1;
				heater_d  = 1'b0;
			end
			REQ_SET_HEAT, REQ_SET_MAINT: begin
				if (over_crit) begin
					rej_d = 1'b1;
				end else begin
					mode_d     = (req_s1 == REQ_SET_MAINT) ? MODE_MAINT : MODE_HEAT;
					start_d    = now_s1;
					setpoint_d = target_s1;
					if (req_s1 == REQ_SET_MAINT) begin
						run_len_d = len_s1;
					end
					if (below_tg) begin
						pump_d   = 1'b1;
						heater_d = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_temp_q <= CRIT_TEMP_RST;
			hyst_q      <= HYST_RST;
			cooldown_q  <= COOLDOWN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_CRIT_TEMP: crit_temp_q <= $signed(cfg_wdata[TEMP_W-1:0]);
				CFG_HYST:      hyst_q      <= cfg_wdata[HYST_W-1:0];
				CFG_COOLDOWN:  cooldown_q  <= cfg_wdata[COOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1    <= req_type;
			now_s1    <= now_seconds;
			water_s1  <= water_temperature;
			target_s1 <= target_temperature;
			len_s1    <= run_seconds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_OFF;
			start_q      <= '0;
			run_len_q    <= '0;
			heater_off_q <= '0;
			setpoint_q   <= SETPOINT_RST;
			pump_q       <= 1'b0;
			heater_q     <= 1'b0;
		end else if (advance) begin
			mode_q       <= mode_d;
			start_q      <= start_d;
			run_len_q    <= run_len_d;
			heater_off_q <= heater_off_d;
			setpoint_q   <= setpoint_d;
			pump_q       <= pump_d;
			heater_q     <= heater_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rej_s2 <= rej_d;
		end
	end

	// result fields mirror the mode state, which only moves together with the result register
	assign out_valid = valid_s2;
	assign pump_on   = pump_q;
	assign heater_on = heater_q;
	assign mode_now  = mode_q;
	assign rejected  = rej_s2;

endmodule

@@ rtl/core/pphmc_checker.sv @@
// Port-level checks for the pool pump and heater mode controller, bound to the top level.
// Depends on pphmc_pkg and pool_pump_heater_mode_controller_defines.svh.
`include "pool_pump_heater_mode_controller_defines.svh"

module pphmc_checker
	import pphmc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic              pump_on,
	input logic              heater_on,
	input logic [MODE_W-1:0] mode_now,
	input logic              rejected
);

	// a stalled result transaction keeps its payload
	`PPHMC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pump_on) && $stable(heater_on) && $stable(mode_now) && $stable(rejected))

	`PPHMC_ASSERT_NOW(a_off_idle, clk, arst_n, out_valid && mode_now == MODE_OFF, !pump_on && !heater_on)

	`PPHMC_ASSERT_NOW(a_filt_pump, clk, arst_n, out_valid && mode_now == MODE_FILT, pump_on && !heater_on)

	// heater never runs dry and only in a heating mode
	`PPHMC_ASSERT_NOW(a_heater_ok, clk, arst_n, out_valid && heater_on, pump_on && (mode_now == MODE_HEAT || mode_now == MODE_MAINT))

endmodule

bind pool_pump_heater_mode_controller pphmc_checker u_pphmc_checker (.*);

@@ sim/pool_pump_heater_mode_controller_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for pool_pump_heater_mode_controller: directed table, then random
// phases under several register settings, checked against a local mode/drive predictor.
// Depends on pphmc_pkg and the controller RTL.
module pool_pump_heater_mode_controller_tb;
	import pphmc_pkg::*;

	// request codes with no function, and the register index with no register behind it
	localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_C = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	localparam int RANDOM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 210;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [TIME_W-1:0] now;
		logic [TEMP_W-1:0] water;
		logic [TEMP_W-1:0] target;
		logic [TIME_W-1:0] run;
	} request_t;

	typedef struct packed {
		logic              pump;
		logic              heater;
		logic [MODE_W-1:0] mode;
		logic              rej;
	} drive_t;

	typedef struct packed {
		logic     typed;
		drive_t   want;
		request_t rq;
	} dir_row_t;

	localparam drive_t DR_NONE = '0;

	localparam int DIR_ROWS = 27;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// straight out of reset, then the spare request codes
		'{1'b1, '{1'b0, 1'b0, MODE_OFF, 1'b0}, '{REQ_TICK, 32'd0, 12'd0, 12'd0, 32'd0}},
		'{1'b1, '{1'b0, 1'b0, MODE_OFF, 1'b0}, '{REQ_SPARE_A, 32'd5, 12'd100, 12'd200, 32'd9}},
		'{1'b1, '{1'b0, 1'b0, MODE_OFF, 1'b0}, '{REQ_SPARE_B, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF,
			32'hFFFF_FFFF}},
		'{1'b1, '{1'b0, 1'b0, MODE_OFF, 1'b0}, '{REQ_SPARE_C, 32'd7, 12'd2047, 12'd2047, 32'd1}},
		// targets above the critical limit
		'{1'b1, '{1'b0, 1'b0, MODE_OFF, 1'b1}, '{REQ_SET_HEAT, 32'd10, 12'd0, 12'd641, 32'd0}},
		'{1'b1, '{1'b0, 1'b0, MODE_OFF, 1'b1}, '{REQ_SET_MAINT, 32'd20, 12'd0, 12'd2047, 32'd5}},
		// filtering runs its length, then stops
		'{1'b1, '{1'b1, 1'b0, MODE_FILT, 1'b0}, '{REQ_SET_FILT, 32'd100, -12'sd1024, 12'd0,
			32'd50}},
		'{1'b0, DR_NONE, '{REQ_TICK, 32'd120, 12'd0, 12'd0, 32'd0}},
		'{1'b1, '{1'b0, 1'b0, MODE_OFF, 1'b0}, '{REQ_TICK, 32'd150, 12'd0, 12'd0, 32'd0}},
		// heating at the limit without demand: drives stay off
		'{1'b1, '{1'b0, 1'b0, MODE_HEAT, 1'b0}, '{REQ_SET_HEAT, 32'd200, 12'd2047, 12'd640,
			32'd0}},
		'{1'b0, DR_NONE, '{REQ_SET_HEAT, 32'd210, -12'sd1024, -12'sd1024, 32'd0}},
		// heating with demand, reach target, cool-down filtering, time out
		'{1'b0, DR_NONE, '{REQ_SET_HEAT, 32'd220, 12'd500, 12'd600, 32'd0}},
		'{1'b0, DR_NONE, '{REQ_TICK, 32'd230, 12'd599, 12'd0, 32'd0}},
		'{1'b0, DR_NONE, '{REQ_TICK, 32'd240, 12'd600, 12'd0, 32'd0}},
		'{1'b0, DR_NONE, '{REQ_TICK, 32'd540, 12'd0, 12'd0, 32'd0}},
		// maintaining across the time wrap: overshoot, cool-down, reheat, time out while hot
		'{1'b0, DR_NONE, '{REQ_SET_MAINT, 32'hFFFF_FF00, 12'd400, 12'd560, 32'd1000}},
		'{1'b0, DR_NONE, '{REQ_TICK, 32'hFFFF_FFF0, 12'd561, 12'd0, 32'd0}},
		'{1'b0, DR_NONE, '{REQ_TICK, 32'h0000_000A, 12'd560, 12'd0, 32'd0}},
		'{1'b0, DR_NONE, '{REQ_TICK, 32'h0000_0130, 12'd560, 12'd0, 32'd0}},
		'{1'b0, DR_NONE, '{REQ_TICK, 32'h0000_0140, 12'd500, 12'd0, 32'd0}},
		'{1'b0, DR_NONE, '{REQ_TICK, 32'h0000_0400, 12'd500, 12'd0, 32'd0}},
		'{1'b1, '{1'b0, 1'b0, MODE_OFF, 1'b0}, '{REQ_SET_OFF, 32'hFFFF_FFFF, 12'd2047, 12'd2047,
			32'hFFFF_FFFF}},
		'{1'b1, '{1'b1, 1'b0, MODE_FILT, 1'b0}, '{REQ_SET_FILT, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF,
			32'hFFFF_FFFF}},
		// heater stops at time zero: sentinel, no cool-down timed
		'{1'b0, DR_NONE, '{REQ_SET_MAINT, 32'd0, 12'd400, 12'd560, 32'd100}},
		'{1'b0, DR_NONE, '{REQ_TICK, 32'd0, 12'd600, 12'd0, 32'd0}},
		'{1'b0, DR_NONE, '{REQ_TICK, 32'd50, 12'd560, 12'd0, 32'd0}},
		'{1'b0, DR_NONE, '{REQ_TICK, 32'd200, 12'd560, 12'd0, 32'd0}}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [REQ_W-1:0]      req_type = '0;
	logic [TIME_W-1:0]     now_seconds = '0;
	logic [TEMP_W-1:0]     water_temperature = '0;
	logic [TEMP_W-1:0]     target_temperature = '0;
	logic [TIME_W-1:0]     run_seconds = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  pump_on;
	logic                  heater_on;
	logic [MODE_W-1:0]     mode_now;
	logic                  rejected;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// typed expectation travels with the transaction from the directed table
	logic   row_typed = 1'b0;
	drive_t row_expect = '0;

	pool_pump_heater_mode_controller i_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of configuration and controller state
	int                ref_crit = CRIT_TEMP_RST;
	int                ref_hyst = HYST_RST;
	logic [TIME_W-1:0] ref_cooldown = COOLDOWN_RST;
	logic [MODE_W-1:0] ctl_mode = MODE_OFF;
	logic [TIME_W-1:0] ctl_start = '0;
	logic [TIME_W-1:0] ctl_run = '0;
	logic [TIME_W-1:0] ctl_heat_off = '0;
	int                ctl_setpoint = SETPOINT_RST;
	logic              ctl_pump = 1'b0;
	logic              ctl_heater = 1'b0;

	drive_t pending_drives [$];
	int     drive_errors = 0;

	// stimulus generator state
	logic [TIME_W-1:0] wall_clock = '0;
	int                aim_temp = SETPOINT_RST;
	int                burst_left = 0;
	logic [9:0]        stall_cnt = '0;

	function automatic void enter_off();
		ctl_mode = MODE_OFF;
		ctl_pump = 1'b0;
		ctl_heater = 1'b0;
	endfunction

	function automatic void enter_filter(logic [TIME_W-1:0] at, logic [TIME_W-1:0] len);
		ctl_mode = MODE_FILT;
		ctl_start = at;
		ctl_run = len;
		ctl_pump = 1'b1;
		ctl_heater = 1'b0;
	endfunction

	function automatic drive_t next_drive_state(request_t rq);
		drive_t            res;
		int                water_i;
		int                target_i;
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] since_off;
		water_i = $signed(rq.water);
		target_i = $signed(rq.target);
		elapsed = rq.now - ctl_start;
		since_off = rq.now - ctl_heat_off;
		res.rej = 1'b0;
		case (rq.req)
		REQ_TICK: begin
			if (ctl_mode == MODE_FILT) begin
				if (elapsed >= ctl_run)
					enter_off();
			end else if (ctl_mode == MODE_HEAT) begin
				if (water_i >= ctl_setpoint)
					enter_filter(rq.now, ref_cooldown);
			end else if (ctl_mode == MODE_MAINT) begin
				if (elapsed >= ctl_run) begin
					if (ctl_heater)
						enter_filter(rq.now, ref_cooldown);
					else
						enter_off();
				end else if (water_i + ref_hyst < ctl_setpoint) begin
					ctl_pump = 1'b1;
					ctl_heater = 1'b1;
					ctl_heat_off = '0;
				end else if (water_i > ctl_setpoint && ctl_heat_off == '0) begin
					// heater off time of zero doubles as "not cooling"
					ctl_pump = 1'b1;
					ctl_heater = 1'b0;
					ctl_heat_off = rq.now;
				end else if (ctl_heat_off != '0) begin
					if (since_off >= ref_cooldown) begin
						ctl_pump = 1'b0;
						ctl_heater = 1'b0;
						ctl_heat_off = '0;
					end
				end
			end
		end
		REQ_SET_OFF: enter_off();
		REQ_SET_FILT: enter_filter(rq.now, rq.run);
		REQ_SET_HEAT, REQ_SET_MAINT: begin
			if (target_i > ref_crit) begin
				res.rej = 1'b1;
			end else begin
				ctl_mode = MODE_HEAT;
				ctl_start = rq.now;
				ctl_setpoint = target_i;
				if (water_i + ref_hyst < ctl_setpoint) begin
					ctl_pump = 1'b1;
					ctl_heater = 1'b1;
				end
				if (rq.req == REQ_SET_MAINT) begin
					ctl_mode = MODE_MAINT;
					ctl_run = rq.run;
				end
			end
		end
		default: ;
		endcase
		res.pump = ctl_pump;
		res.heater = ctl_heater;
		res.mode = ctl_mode;
		return res;
	endfunction

	// accepted transactions, register writes and results, all sampled at the rising edge
	always @(posedge clk) begin : monitor
		request_t acc;
		drive_t   pred;
		drive_t   want;
		drive_t   got;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
				CFG_CRIT_TEMP: ref_crit = $signed(cfg_wdata[TEMP_W-1:0]);
				CFG_HYST: ref_hyst = cfg_wdata[HYST_W-1:0];
				CFG_COOLDOWN: ref_cooldown = cfg_wdata[COOL_W-1:0];
				default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				acc = '{req_type, now_seconds, water_temperature, target_temperature, run_seconds};
				pred = next_drive_state(acc);
				pending_drives.push_back(row_typed ? row_expect : pred);
			end
			if (out_valid && out_ready) begin
				got = '{pump_on, heater_on, mode_now, rejected};
				if (pending_drives.size() == 0) begin
					drive_errors++;
					if (drive_errors <= 10)
						$display("%0t: unexpected result pump %0b heater %0b mode %0d rej %0b",
							$time, got.pump, got.heater, got.mode, got.rej);
				end else begin
					want = pending_drives.pop_front();
					if (got !== want) begin
						drive_errors++;
						if (drive_errors <= 10) begin
							$write("%0t: drive mismatch exp pump %0b heater %0b mode %0d rej %0b,",
								$time, want.pump, want.heater, want.mode, want.rej);
							$display(" got pump %0b heater %0b mode %0d rej %0b",
								got.pump, got.heater, got.mode, got.rej);
						end
					end
				end
			end
		end
	end

	// receiver stalls: pattern chosen by the upper counter bits, some stretches always ready
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1'b1;
		case (stall_cnt[9:7])
		3'd0, 3'd1: out_ready <= 1'b1;
		3'd2: out_ready <= 1'($urandom_range(0, 1));
		3'd3: out_ready <= (stall_cnt[2:0] != 3'd0);
		3'd4: out_ready <= (stall_cnt[4:3] != 2'd3);
		3'd5: out_ready <= ($urandom_range(0, 3) == 0);
		default: out_ready <= stall_cnt[0];
		endcase
	end

	task automatic offer_request(input request_t rq, input logic typed, input drive_t fixed);
		in_valid <= 1'b1;
		req_type <= rq.req;
		now_seconds <= rq.now;
		water_temperature <= rq.water;
		target_temperature <= rq.target;
		run_seconds <= rq.run;
		row_typed <= typed;
		row_expect <= fixed;
		do
			@(posedge clk);
		while (!in_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 8);
		end
	endtask

	// let the monitor log the last accepted transaction before polling the queue
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_drives.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(input int crit, input int hyst, input int cool);
		logic [CFG_DATA_W-1:0] word [4];
		logic [CFG_IDX_W-1:0]  idx [4];
		// upper bits beyond each register width are don't-care, so randomize them
		word[0] = {(CFG_DATA_W-TEMP_W)'($urandom), TEMP_W'(crit)};
		word[1] = {(CFG_DATA_W-HYST_W)'($urandom), HYST_W'(hyst)};
		word[2] = COOL_W'(cool);
		word[3] = CFG_DATA_W'($urandom);
		idx[0] = CFG_CRIT_TEMP;
		idx[1] = CFG_HYST;
		idx[2] = CFG_COOLDOWN;
		idx[3] = CFG_SPARE;
		for (int k = 0; k < 4; k++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[k];
			cfg_wdata <= word[k];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	function automatic int clamp_temp(int t);
		if (t < -1024)
			return -1024;
		if (t > 2047)
			return 2047;
		return t;
	endfunction

	// mostly commands followed by ticks at small time steps, temperatures near the setpoint
	function automatic request_t random_request();
		request_t rq;
		int       pick;
		int       span;
		int       wt;
		int       tg;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			rq.req = REQ_TICK;
		else if (pick < 60)
			rq.req = REQ_SET_OFF;
		else if (pick < 70)
			rq.req = REQ_SET_FILT;
		else if (pick < 80)
			rq.req = REQ_SET_HEAT;
		else if (pick < 92)
			rq.req = REQ_SET_MAINT;
		else if (pick < 96)
			rq.req = REQ_W'($urandom_range(REQ_SPARE_A, REQ_SPARE_C));
		else
			rq.req = REQ_W'($urandom);

		pick = $urandom_range(0, 99);
		if (pick < 70)
			wall_clock += $urandom_range(0, 60);
		else if (pick < 95)
			wall_clock += $urandom_range(0, 600);
		else if (pick < 98)
			wall_clock += $urandom_range(0, 70000);
		else if (pick < 99)
			wall_clock = $urandom;
		else
			wall_clock = '0;
		rq.now = wall_clock;

		if ($urandom_range(0, 9) < 6)
			tg = ref_crit + 5 - int'($urandom_range(0, 155));
		else
			tg = int'($urandom_range(0, 3071)) - 1024;
		tg = clamp_temp(tg);
		if ((rq.req == REQ_SET_HEAT || rq.req == REQ_SET_MAINT) && tg <= ref_crit)
			aim_temp = tg;
		rq.target = TEMP_W'(tg);

		span = ref_hyst + 24;
		if ($urandom_range(0, 99) < 65)
			wt = aim_temp + int'($urandom_range(0, 2 * span)) - span;
		else
			wt = int'($urandom_range(0, 3071)) - 1024;
		rq.water = TEMP_W'(clamp_temp(wt));

		pick = $urandom_range(0, 9);
		if (pick < 7)
			rq.run = $urandom_range(0, 1500);
		else if (pick < 9)
			rq.run = $urandom_range(0, 20);
		else
			rq.run = $urandom;
		return rq;
	endfunction

	initial begin
		int crit;
		int hyst;
		int cool;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			offer_request(DIRECTED[i].rq, DIRECTED[i].typed, DIRECTED[i].want);
		drain_pipeline();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
			0: begin
				crit = CRIT_TEMP_RST;
				hyst = HYST_RST;
				cool = COOLDOWN_RST;
			end
			1: begin
				crit = 2047;
				hyst = 0;
				cool = 0;
			end
			2: begin
				crit = -1024;
				hyst = 255;
				cool = 65535;
			end
			3: begin
				crit = 300 + $urandom_range(0, 600);
				hyst = $urandom_range(0, 255);
				cool = $urandom_range(0, 400);
			end
			4: begin
				crit = 560 + $urandom_range(0, 160);
				hyst = $urandom_range(0, 40);
				cool = $urandom_range(1, 120);
			end
			default: begin
				crit = int'($urandom_range(0, 3071)) - 1024;
				hyst = $urandom_range(0, 255);
				cool = $urandom_range(0, 2000);
			end
			endcase
			// phase 0 keeps the reset values
			if (phase != 0)
				load_config(crit, hyst, cool);
			repeat (ITEMS_PER_PHASE) begin
				offer_request(random_request(), 1'b0, DR_NONE);
				if ($urandom_range(0, 99) == 0)
					drain_pipeline();
			end
			drain_pipeline();
		end

		repeat (10) @(posedge clk);
		if (drive_errors == 0 && pending_drives.size() == 0)
			$display("pool_pump_heater_mode_controller: match");
		else
			$display("pool_pump_heater_mode_controller: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("pool_pump_heater_mode_controller: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/pphmc_pkg.sv
rtl/core/pool_pump_heater_mode_controller.sv
rtl/core/pphmc_checker.sv
sim/pool_pump_heater_mode_controller_tb.sv
